// ===== rtl/core/mpbd_pkg.sv =====
package mpbd_pkg;

  // Fixed geometry of the scan item and of the button set.
  localparam int PORTS       = 5;
  localparam int PIN_W       = 16;
  localparam int MAX_BUTTONS = 8;
  localparam int THR_W       = 8;
  localparam int CFG_INDEX_W = 8;

  // Port positions inside a scan item.
  localparam int PORT_A = 0;
  localparam int PORT_B = 1;
  localparam int PORT_C = 2;
  localparam int PORT_D = 3;
  localparam int PORT_E = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_THRESHOLD   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_THRESHOLD = 8'd1;

  localparam logic [THR_W-1:0] PRESS_THRESHOLD_RESET   = 8'd5;
  localparam logic [THR_W-1:0] RELEASE_THRESHOLD_RESET = 8'd5;

  typedef logic [PORTS-1:0][PIN_W-1:0] port_words_t;

  typedef struct packed {
    logic [THR_W-1:0] press;
    logic [THR_W-1:0] release_thr;
  } thresholds_t;

  // Pins that belong to each button, one mask per port (A to E).
  localparam logic [PIN_W-1:0] PIN_MAP [MAX_BUTTONS][PORTS] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h003C},
    '{16'h0000, 16'h0000, 16'hC003, 16'h0000, 16'h0000},
    '{16'h000F, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'h00C0, 16'h0000, 16'h0030, 16'h0000, 16'h0000},
    '{16'h0000, 16'h00F0, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 16'h0000, 16'h0078, 16'h0000},
    '{16'h0000, 16'h0000, 16'h1C00, 16'h0001, 16'h0000},
    '{16'h3C00, 16'h0000, 16'h0000, 16'h0000, 16'h0000}
  };

  // A button reads pressed when any of its mapped pins is low.
  function automatic logic button_active(input int unsigned b, input port_words_t ports);
    logic hit;
    hit = 1'b0;
    for (int p = 0; p < PORTS; p++) begin
      hit = hit | (|(~ports[p] & PIN_MAP[b][p]));
    end
    return hit;
  endfunction

endpackage

// ===== rtl/core/mpbd_scan_if.sv =====
interface mpbd_scan_if;
  logic                          valid;
  logic                          ready;
  logic [mpbd_pkg::PIN_W-1:0]    port_a_pins;
  logic [mpbd_pkg::PIN_W-1:0]    port_b_pins;
  logic [mpbd_pkg::PIN_W-1:0]    port_c_pins;
  logic [mpbd_pkg::PIN_W-1:0]    port_d_pins;
  logic [mpbd_pkg::PIN_W-1:0]    port_e_pins;

  modport source (output valid, port_a_pins, port_b_pins, port_c_pins, port_d_pins,
                  port_e_pins, input ready);
  modport sink (input valid, port_a_pins, port_b_pins, port_c_pins, port_d_pins,
                port_e_pins, output ready);
endinterface

// ===== rtl/core/mpbd_result_if.sv =====
interface mpbd_result_if;
  logic                                valid;
  logic                                ready;
  logic [mpbd_pkg::MAX_BUTTONS-1:0]    button_states;

  modport source (output valid, button_states, input ready);
  modport sink (input valid, button_states, output ready);
endinterface

// ===== rtl/core/mpbd_cfg_if.sv =====
interface mpbd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mpbd_pkg::CFG_INDEX_W-1:0]    index;
  logic [mpbd_pkg::THR_W-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mpbd_button.sv =====
module mpbd_button (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    raw,
  input  mpbd_pkg::thresholds_t   thr,
  output logic                    flag,
  output logic                    flag_next
);

  logic [mpbd_pkg::THR_W-1:0] press_count;
  logic [mpbd_pkg::THR_W-1:0] press_count_next;
  logic [mpbd_pkg::THR_W-1:0] release_count;
  logic [mpbd_pkg::THR_W-1:0] release_count_next;
  logic [mpbd_pkg::THR_W-1:0] press_inc;
  logic [mpbd_pkg::THR_W-1:0] release_inc;

  // Counters stay below the threshold, so the increment never wraps.
  always_comb begin
    press_inc          = press_count + 8'd1;
    release_inc        = release_count + 8'd1;
    flag_next          = flag;
    press_count_next   = '0;
    release_count_next = '0;
    if (raw && !flag) begin
      if (press_inc >= thr.press) begin
        flag_next = 1'b1;
      end else begin
        press_count_next = press_inc;
      end
    end else if (!raw && flag) begin
      if (release_inc >= thr.release_thr) begin
        flag_next = 1'b0;
      end else begin
        release_count_next = release_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag          <= 1'b0;
      press_count   <= '0;
      release_count <= '0;
    end else if (advance) begin
      flag          <= flag_next;
      press_count   <= press_count_next;
      release_count <= release_count_next;
    end
  end

endmodule

// ===== rtl/core/multi_pin_button_debouncer.sv =====
// A scan accepted on the scan channel is held in the input stage, then moves into the
// result register, which offers its debounced byte on the result channel.
// Throughput: one scan per cycle while result.ready holds; the input register and the result
// register let a new request enter while a finished result still waits to be taken.
// Reset (rst, synchronous, active high) clears all counters and flags, empties both
// stages and sets both thresholds to 5.
module multi_pin_button_debouncer #(
  parameter int BUTTON_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst,
  mpbd_scan_if.sink     scan,
  mpbd_result_if.source result,
  mpbd_cfg_if.sink      cfg
);

  // Threshold registers. The port is always ready; writes to unknown indexes
  // are dropped.
  mpbd_pkg::thresholds_t thr;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.press       <= mpbd_pkg::PRESS_THRESHOLD_RESET;
      thr.release_thr <= mpbd_pkg::RELEASE_THRESHOLD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        mpbd_pkg::REG_PRESS_THRESHOLD:   thr.press       <= cfg.data;
        mpbd_pkg::REG_RELEASE_THRESHOLD: thr.release_thr <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input stage: the accepted scan is held here while the button logic works
  // on it. The stage moves on whenever the result register is free or is
  // being emptied in the same cycle, so requests flow back to back.
  logic                        stage_valid;
  mpbd_pkg::port_words_t       stage_ports;
  logic                        advance;

  assign advance    = stage_valid && (!result.valid || result.ready);
  assign scan.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (scan.ready) begin
      stage_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      stage_ports[mpbd_pkg::PORT_A] <= scan.port_a_pins;
      stage_ports[mpbd_pkg::PORT_B] <= scan.port_b_pins;
      stage_ports[mpbd_pkg::PORT_C] <= scan.port_c_pins;
      stage_ports[mpbd_pkg::PORT_D] <= scan.port_d_pins;
      stage_ports[mpbd_pkg::PORT_E] <= scan.port_e_pins;
    end
  end

  // One debounce cell per scanned button. The cells update their counters
  // and flags only when the staged scan moves into the result register.
  // Buttons past BUTTON_COUNT are not scanned and always read released.
  logic [mpbd_pkg::MAX_BUTTONS-1:0] flags;
  logic [mpbd_pkg::MAX_BUTTONS-1:0] flags_next;

  for (genvar i = 0; i < mpbd_pkg::MAX_BUTTONS; i++) begin : g_button
    if (i < BUTTON_COUNT) begin : g_used
      mpbd_button u_button (
        .clk       (clk),
        .rst       (rst),
        .advance   (advance),
        .raw       (mpbd_pkg::button_active(i, stage_ports)),
        .thr       (thr),
        .flag      (flags[i]),
        .flag_next (flags_next[i])
      );
    end else begin : g_unused
      assign flags[i]      = 1'b0;
      assign flags_next[i] = 1'b0;
    end
  end

  // Result register: holds the debounced byte after the scan is applied.
  logic                             out_valid;
  logic [mpbd_pkg::MAX_BUTTONS-1:0] out_states;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_states <= flags_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.button_states = out_states;

`ifndef SYNTHESIS
  // An accepted scan always lands in the input stage.
  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    scan.valid && scan.ready |=> stage_valid)
    else $error("accepted scan did not reach the input stage");

  // A fresh result only appears after the stage moved on.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without a staged scan");

  // Debounce state changes only when a scan is applied.
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(flags))
    else $error("debounced flags changed without a scan");

  // The delivered byte matches the flags that were just committed.
  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_states == flags)
    else $error("result byte differs from the committed flags");
`endif

endmodule
